>>> design/hdlf_pkg.sv
package hdlf_pkg;

  localparam int BYTES_PER_LINE_DEF = 16;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_SEVEN = 7'h37;
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_NL    = 7'h0A;

  localparam int POS_W = 3;

  localparam logic [POS_W-1:0] POS_A3  = 3'd0;
  localparam logic [POS_W-1:0] POS_A2  = 3'd1;
  localparam logic [POS_W-1:0] POS_A1  = 3'd2;
  localparam logic [POS_W-1:0] POS_A0  = 3'd3;
  localparam logic [POS_W-1:0] POS_SEP = 3'd4;
  localparam logic [POS_W-1:0] POS_DH  = 3'd5;
  localparam logic [POS_W-1:0] POS_DL  = 3'd6;
  localparam logic [POS_W-1:0] POS_NL  = 3'd7;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] byte_address;
    logic        open_line;
    logic        close_line;
    logic        colon_sep;
  } item_t;

  typedef struct packed {
    logic [6:0]       text_char;
    logic             is_final;
    logic             is_nl;
    logic [POS_W-1:0] next_pos;
  } char_sel_t;

  function automatic logic [6:0] hex_digit(input logic [3:0] v);
    hex_digit = (v < 4'd10) ? (CH_ZERO + {3'b000, v}) : (CH_SEVEN + {3'b000, v});
  endfunction

endpackage

>>> design/hdlf_char_sel.sv
module hdlf_char_sel
  import hdlf_pkg::*;
(
  input  item_t            item,
  input  logic [POS_W-1:0] pos,
  output char_sel_t        sel
);

  always_comb begin
    sel.text_char = CH_NL;
    sel.is_final  = 1'b0;
    sel.is_nl     = 1'b0;
    sel.next_pos  = POS_NL;
    case (pos)
      POS_A3: begin
        sel.text_char = hex_digit(item.byte_address[15:12]);
        sel.next_pos  = POS_A2;
      end
      POS_A2: begin
        sel.text_char = hex_digit(item.byte_address[11:8]);
        sel.next_pos  = POS_A1;
      end
      POS_A1: begin
        sel.text_char = hex_digit(item.byte_address[7:4]);
        sel.next_pos  = POS_A0;
      end
      POS_A0: begin
        sel.text_char = hex_digit(item.byte_address[3:0]);
        sel.next_pos  = POS_SEP;
      end
      POS_SEP: begin
        sel.text_char = item.colon_sep ? CH_COLON : CH_SPACE;
        sel.next_pos  = POS_DH;
      end
      POS_DH: begin
        sel.text_char = hex_digit(item.data_byte[7:4]);
        sel.next_pos  = POS_DL;
      end
      POS_DL: begin
        sel.text_char = hex_digit(item.data_byte[3:0]);
        sel.is_final  = !item.close_line;
        sel.next_pos  = POS_NL;
      end
      POS_NL: begin
        sel.text_char = CH_NL;
        sel.is_final  = 1'b1;
        sel.is_nl     = 1'b1;
        sel.next_pos  = POS_NL;
      end
      default: begin
        sel.text_char = CH_NL;
        sel.is_final  = 1'b1;
        sel.is_nl     = 1'b1;
        sel.next_pos  = POS_NL;
      end
    endcase
  end

endmodule

>>> design/hex_dump_line_formatter_top.sv
// The first character of an item is registered from the item register into the output register once that is free.
// Throughput: one character per cycle through the single output character register while out_tready holds;
// an item yields 3 characters, plus 4 when it opens a line and 1 when it closes one
// (53 characters for a full line of 16 bytes). The next item is taken as the current one ends.
// Reset (rst_n low, synchronous): empties the item and output registers, column to zero.
module hex_dump_line_formatter_top
  import hdlf_pkg::*;
#(
  parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [23:8] byte_address
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] text_char, [7] zero
  output logic        out_tlast,  // run_end
  output logic        out_tuser   // [0] line_end
);

  localparam int COL_W = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
  localparam logic [COL_W:0] LINE_LEN = (COL_W + 1)'(BYTES_PER_LINE);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W:0]   col_inc;
  logic             item_vld_r;
  item_t            item_r, item_nxt;
  logic [POS_W-1:0] pos_r;
  char_sel_t        cs;
  logic             in_xfer, load, item_done;
  logic             out_vld_r, out_last_r, out_nl_r;
  logic [6:0]       out_char_r;

  hdlf_char_sel u_char_sel (
    .item (item_r),
    .pos  (pos_r),
    .sel  (cs)
  );

  assign load      = item_vld_r && (!out_vld_r || out_tready);
  assign item_done = load && cs.is_final;
  assign in_tready = !item_vld_r || item_done;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    col_inc                = {1'b0, col_r} + (COL_W + 1)'(1);
    item_nxt.data_byte     = in_tdata[7:0];
    item_nxt.byte_address  = in_tdata[23:8];
    item_nxt.open_line     = (col_r == '0);
    item_nxt.close_line    = (col_inc == LINE_LEN) || in_tlast;
    item_nxt.colon_sep     = (col_r[1:0] != 2'b00);
    col_nxt                = item_nxt.close_line ? '0 : col_inc[COL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      item_vld_r <= 1'b0;
      pos_r      <= POS_A3;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_r      <= col_nxt;
        item_vld_r <= 1'b1;
        pos_r      <= item_nxt.open_line ? POS_A3 : POS_SEP;
      end else if (item_done) begin
        item_vld_r <= 1'b0;
      end else if (load) begin
        pos_r <= cs.next_pos;
      end
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= item_nxt;
    end
    if (load) begin
      out_char_r <= cs.text_char;
      out_last_r <= cs.is_final;
      out_nl_r   <= cs.is_nl;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_nl_r;

  a_nl_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[6:0] == CH_NL))
    else $error("newline does not end its run");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < LINE_LEN)
    else $error("column out of range");

  a_nl_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r && (pos_r == POS_NL) |-> item_r.close_line)
    else $error("newline position on a line that stays open");

  a_addr_only_on_open: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r && (pos_r == POS_A3) |-> item_r.open_line)
    else $error("address emitted mid-line");

  a_close_resets_col: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && item_nxt.close_line |=> col_r == '0)
    else $error("column not cleared after line close");

endmodule
